[src/dmfa_pkg.sv]
// Shared types and constants for the direct mapped / fully associative LFU cache.
package dmfa_pkg;

  localparam int LINES_DEF       = 8;
  localparam int OFFSET_BITS_DEF = 2;
  localparam int ADDR_W_DEF      = 8;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int HITS_W   = 16;
  localparam int USED_W   = 3;
  localparam int M_DATA_W = 16;

  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_ASSOC  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_FIN
  } state_t;

  // search token handed along the row of lines
  typedef struct packed {
    logic              vld;
    logic              found;
    logic              hit;
    logic              repl;
    logic              have_best;
    logic [HITS_W-1:0] best;
    logic [WORD_W-1:0] data;
  } tok_t;

  // line update, broadcast at the end of a request
  typedef struct packed {
    logic              en;
    logic              fill;
    logic [WORD_W-1:0] data;
  } upd_t;

endpackage

[src/dmfa_div.sv]
// Division of the block index by the constant line count, by reciprocal multiplication.
module dmfa_div #(
  parameter int LINES      = dmfa_pkg::LINES_DEF,
  parameter int BLOCK_BITS = dmfa_pkg::ADDR_W_DEF - dmfa_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [BLOCK_BITS-1:0]     dividend,
  output logic                      done,
  output logic [BLOCK_BITS-1:0]     quo,
  output logic [$clog2(LINES)-1:0]  rem
);

  localparam int LW  = $clog2(LINES);
  localparam int SH  = BLOCK_BITS + LW;
  localparam int PW  = 2 * BLOCK_BITS + LW + 1;
  localparam int BKW = BLOCK_BITS + LW;
  // ceil(2^SH / LINES): exact quotient for every dividend of BLOCK_BITS bits
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(LINES) - 64'd1) / 64'(LINES);

  logic                  busy;
  logic [BLOCK_BITS-1:0] dvd;
  logic [PW-1:0]         prod;
  logic [BKW-1:0]        back;

  always_comb begin
    prod = PW'(dvd) * PW'(RECIP);
    quo  = prod[SH +: BLOCK_BITS];
    back = BKW'(quo) * BKW'(LINES);
    rem  = LW'(BKW'(dvd) - back);
    done = busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
  end

endmodule

[src/dmfa_cell.sv]
// One cache line: holds its state, examines the passing token, registers it onward.
module dmfa_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 3,
  parameter int TAG_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mode,
  input  logic [TAG_W-1:0]     tag,
  input  logic [IDX_W-1:0]     dm_line,
  input  dmfa_pkg::tok_t       tok_in,
  input  logic [IDX_W-1:0]     sel_in,
  output dmfa_pkg::tok_t       tok_out,
  output logic [IDX_W-1:0]     sel_out,
  input  dmfa_pkg::upd_t       upd,
  input  logic [IDX_W-1:0]     upd_idx
);

  logic                          valid;
  logic [TAG_W-1:0]              line_tag;
  logic [dmfa_pkg::HITS_W-1:0]   hits;
  logic [dmfa_pkg::WORD_W-1:0]   line_data;

  dmfa_pkg::tok_t                tok_next;
  logic [IDX_W-1:0]              sel_next;
  logic                          match;
  logic                          mine;

  assign match = valid && (line_tag == tag);
  assign mine  = upd.en && (upd_idx == IDX_W'(INDEX));

  always_comb begin
    tok_next = tok_in;
    sel_next = sel_in;
    if (tok_in.vld) begin
      if (mode == dmfa_pkg::MODE_DIRECT) begin
        if (dm_line == IDX_W'(INDEX)) begin
          tok_next.found = 1'b1;
          tok_next.hit   = match;
          tok_next.repl  = valid && !match;
          tok_next.data  = line_data;
          sel_next       = IDX_W'(INDEX);
        end
      end else if (!tok_in.found) begin
        if (match) begin
          tok_next.found = 1'b1;
          tok_next.hit   = 1'b1;
          tok_next.data  = line_data;
          sel_next       = IDX_W'(INDEX);
        end else if (!valid) begin
          tok_next.found = 1'b1;
          sel_next       = IDX_W'(INDEX);
        end else if (!tok_in.have_best || hits < tok_in.best) begin
          tok_next.have_best = 1'b1;
          tok_next.best      = hits;
          sel_next           = IDX_W'(INDEX);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.found     <= tok_next.found;
    tok_out.hit       <= tok_next.hit;
    tok_out.repl      <= tok_next.repl;
    tok_out.have_best <= tok_next.have_best;
    tok_out.best      <= tok_next.best;
    tok_out.data      <= tok_next.data;
    sel_out           <= sel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      line_tag <= '0;
      hits     <= '0;
    end else if (mine) begin
      if (upd.fill) begin
        valid    <= 1'b1;
        line_tag <= tag;
        hits     <= dmfa_pkg::HITS_W'(1);
      end else if (hits != '1) begin
        hits <= hits + dmfa_pkg::HITS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mine && upd.fill) begin
      line_data <= upd.data;
    end
  end

endmodule

[src/dm_fa_lfu_cache_lookup.sv]
// Top level of the direct mapped / fully associative LFU read cache.
//
// Read cache of LINES four-byte lines. Each request carries a byte address and
// the four bytes of its block, stored only on a fill; the answer gives the byte,
// hit and replaced flags and the line used. mapping_mode 0 places blocks direct
// mapped, 1 fully associative with least-frequently-used replacement (first line
// with the lowest saturating hit count). Requests are handled one at a time: a
// search token walks the row of lines one line a cycle; a direct mapped request
// first passes the divide state, which splits the block index into line and
// tag. The next request is taken once the result has been loaded into the
// output register; a stalled output holds the block. Mode writes do not clear
// the cache.
module dm_fa_lfu_cache_lookup #(
  parameter int LINES       = dmfa_pkg::LINES_DEF,
  parameter int OFFSET_BITS = dmfa_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_W      = dmfa_pkg::ADDR_W_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic                                         cfg_data,   // mapping_mode
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // address, fill_byte_0, fill_byte_1, fill_byte_2, fill_byte_3
  input  logic [((ADDR_W + dmfa_pkg::WORD_W + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // read_data, hit, replaced, line_used
  output logic [dmfa_pkg::M_DATA_W-1:0]                m_tdata
);

  localparam int IDX_W      = $clog2(LINES);
  localparam int BLOCK_BITS = ADDR_W - OFFSET_BITS;
  localparam int BW         = dmfa_pkg::BYTE_W;

  dmfa_pkg::state_t             state, state_next;
  logic                         mapping_mode;
  logic                         mode_q;
  logic [BLOCK_BITS-1:0]        block_q;
  logic [OFFSET_BITS-1:0]       off_q;
  logic [dmfa_pkg::WORD_W-1:0]  fill_q;
  logic                         start;
  dmfa_pkg::tok_t               fin_tok;
  logic [IDX_W-1:0]             fin_sel;

  logic                         s_acc;
  logic                         div_start;
  logic                         div_done;
  logic [BLOCK_BITS-1:0]        quo;
  logic [IDX_W-1:0]             rem;
  logic [BLOCK_BITS-1:0]        ctx_tag;
  logic                         out_free;
  logic                         out_load;
  dmfa_pkg::upd_t               upd;

  dmfa_pkg::tok_t               tok_chain [LINES+1];
  logic [IDX_W-1:0]             sel_chain [LINES+1];
  logic [LINES:0]               tok_vlds;

  logic                         res_hit;
  logic                         res_repl;
  logic [dmfa_pkg::WORD_W-1:0]  res_word;
  logic [OFFSET_BITS+1:0]       off_ext;
  logic [1:0]                   byte_sel;
  logic [IDX_W+2:0]             used_ext;

  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign div_start = s_acc && (mapping_mode == dmfa_pkg::MODE_DIRECT);
  assign out_free  = !m_tvalid || m_tready;
  assign ctx_tag   = (mode_q == dmfa_pkg::MODE_ASSOC) ? block_q : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_mode <= dmfa_pkg::MODE_DIRECT;
    end else if (cfg_valid && cfg_ready) begin
      mapping_mode <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dmfa_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_next = (mapping_mode == dmfa_pkg::MODE_ASSOC) ? dmfa_pkg::ST_SCAN
                                                              : dmfa_pkg::ST_DIV;
        end
      end
      dmfa_pkg::ST_DIV:  if (div_done) state_next = dmfa_pkg::ST_SCAN;
      dmfa_pkg::ST_SCAN: if (tok_chain[LINES].vld) state_next = dmfa_pkg::ST_FIN;
      dmfa_pkg::ST_FIN:  if (out_free) state_next = dmfa_pkg::ST_IDLE;
      default:           state_next = dmfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    case (state)
      dmfa_pkg::ST_IDLE: s_tready = 1'b1;
      dmfa_pkg::ST_FIN:  out_load = out_free;
      default: begin
        s_tready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmfa_pkg::ST_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= (state_next == dmfa_pkg::ST_SCAN) && (state != dmfa_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      mode_q  <= mapping_mode;
      block_q <= s_tdata[ADDR_W-1:OFFSET_BITS];
      off_q   <= s_tdata[OFFSET_BITS-1:0];
      fill_q  <= s_tdata[ADDR_W + dmfa_pkg::WORD_W - 1:ADDR_W];
    end
    if (state == dmfa_pkg::ST_SCAN && tok_chain[LINES].vld) begin
      fin_tok <= tok_chain[LINES];
      fin_sel <= sel_chain[LINES];
    end
  end

  dmfa_div #(
    .LINES      (LINES),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata[ADDR_W-1:OFFSET_BITS]),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_comb begin
    tok_chain[0]           = '0;
    tok_chain[0].vld       = start;
    sel_chain[0]           = '0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < LINES; gi++) begin : g_line
      dmfa_cell #(
        .INDEX (gi),
        .IDX_W (IDX_W),
        .TAG_W (BLOCK_BITS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .mode    (mode_q),
        .tag     (ctx_tag),
        .dm_line (rem),
        .tok_in  (tok_chain[gi]),
        .sel_in  (sel_chain[gi]),
        .tok_out (tok_chain[gi+1]),
        .sel_out (sel_chain[gi+1]),
        .upd     (upd),
        .upd_idx (fin_sel)
      );
    end
    for (gi = 0; gi <= LINES; gi++) begin : g_vld
      assign tok_vlds[gi] = tok_chain[gi].vld;
    end
  endgenerate

  always_comb begin
    res_hit   = fin_tok.hit;
    res_repl  = fin_tok.found ? fin_tok.repl : 1'b1;
    res_word  = res_hit ? fin_tok.data : fill_q;
    off_ext   = (OFFSET_BITS+2)'(off_q);
    byte_sel  = off_ext[1:0];
    used_ext  = (IDX_W+3)'(fin_sel);
    upd.en    = out_load;
    upd.fill  = !res_hit;
    upd.data  = fill_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(dmfa_pkg::M_DATA_W - dmfa_pkg::USED_W - 2 - BW){1'b0}},
                  used_ext[dmfa_pkg::USED_W-1:0], res_repl, res_hit,
                  res_word[byte_sel*BW +: BW]};
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vlds))
    else $error("more than one search token in the row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    (tok_vlds != '0) |-> (state == dmfa_pkg::ST_SCAN))
    else $error("search token outside scan");

  a_hit_not_repl: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(res_hit && res_repl))
    else $error("result flagged both hit and replaced");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == dmfa_pkg::ST_DIV))
    else $error("divider finished outside divide state");

endmodule

[tb/dm_fa_lfu_cache_lookup_tb.sv]
// Self-checking testbench for the direct mapped / fully associative LFU lookup cache.
`timescale 1ns / 100ps

module dm_fa_lfu_cache_lookup_tb;

  localparam int NLINES = dmfa_pkg::LINES_DEF;
  localparam int OFF_W  = dmfa_pkg::OFFSET_BITS_DEF;
  localparam int ADDR_W = dmfa_pkg::ADDR_W_DEF;
  localparam int BLK_W  = ADDR_W - OFF_W;
  localparam int TDATA_W = ((ADDR_W + dmfa_pkg::WORD_W + 7) / 8) * 8;
  localparam int PREP_HITS = 8;
  localparam int NUM_DIRECTED = 22;

  typedef struct packed {
    logic [dmfa_pkg::BYTE_W-1:0] rd;
    logic                        hit;
    logic                        repl;
    logic [dmfa_pkg::USED_W-1:0] line_idx;
  } lookup_res_t;

  typedef enum logic {ROW_LOOKUP, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic                        mode;
    logic [ADDR_W-1:0]           addr;
    logic [dmfa_pkg::WORD_W-1:0] fill;
    logic                        typed;
    lookup_res_t                 want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_data;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [TDATA_W-1:0]        s_tdata;   // address, fill_byte_0, fill_byte_1, fill_byte_2, fill_byte_3
  logic                      m_tvalid;
  logic                      m_tready;
  logic [dmfa_pkg::M_DATA_W-1:0] m_tdata;   // read_data, hit, replaced, line_used

  // predictor state
  logic                          mdl_mode;
  logic                          mdl_valid [NLINES];
  logic [BLK_W-1:0]              mdl_tag   [NLINES];
  logic [dmfa_pkg::HITS_W-1:0]   mdl_count [NLINES];
  logic [dmfa_pkg::WORD_W-1:0]   mdl_data  [NLINES];

  lookup_res_t               pending_lookups [$];
  int unsigned               err_count = 0;
  int unsigned               sent_count = 0;
  int unsigned               mode_writes = 0;
  int unsigned               pred_hits = 0;
  int unsigned               pred_repls = 0;
  int unsigned               burst_left = 0;
  bit                        gaps_enabled = 1'b1;
  bit                        tx_live = 1'b0;
  bit                        rx_free = 1'b0;
  logic [15:0]               rx_pat = 16'hFFFF;
  logic [3:0]                rx_pos = '0;

  dm_fa_lfu_cache_lookup dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // directed requests, mode 0 after reset
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_LOOKUP, 1'b0, 8'h00, 32'h44332211, 1'b1, '{8'h11, 1'b0, 1'b0, 3'd0}},
    '{ROW_LOOKUP, 1'b0, 8'h03, 32'hFFFFFFFF, 1'b1, '{8'h44, 1'b1, 1'b0, 3'd0}},
    '{ROW_LOOKUP, 1'b0, 8'hFF, 32'hDDCCBBAA, 1'b1, '{8'hDD, 1'b0, 1'b0, 3'd7}},
    '{ROW_LOOKUP, 1'b0, 8'hE1, 32'h78563412, 1'b1, '{8'h34, 1'b0, 1'b1, 3'd0}},
    '{ROW_LOOKUP, 1'b0, 8'h1C, 32'h00000000, 1'b1, '{8'h00, 1'b0, 1'b1, 3'd7}},
    '{ROW_LOOKUP, 1'b0, 8'h1F, 32'h5A5A5A5A, 1'b1, '{8'h00, 1'b1, 1'b0, 3'd7}},
    '{ROW_LOOKUP, 1'b0, 8'h20, 32'h01020304, 1'b0, '0},
    '{ROW_MODE,   dmfa_pkg::MODE_ASSOC, 8'h00, 32'h0, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h20, 32'hA5A5A5A5, 1'b1, '{8'hA5, 1'b0, 1'b0, 3'd1}},
    '{ROW_LOOKUP, 1'b0, 8'h04, 32'hC3C3C3C3, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h40, 32'h0F1E2D3C, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h51, 32'h4B5A6978, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h62, 32'h8796A5B4, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h73, 32'hC3D2E1F0, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'hFF, 32'hFFFFFFFF, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h1C, 32'h13579BDF, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h1E, 32'h00000000, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h00, 32'h2468ACE0, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h80, 32'h11111111, 1'b0, '0},
    '{ROW_MODE,   dmfa_pkg::MODE_DIRECT, 8'h00, 32'h0, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'h21, 32'h99999999, 1'b0, '0},
    '{ROW_LOOKUP, 1'b0, 8'hFE, 32'h76543210, 1'b0, '0}
  };

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (err_count < 40)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    err_count++;
  endtask

  function automatic void load_line(input int unsigned slot, input logic [BLK_W-1:0] tag,
                                    input logic [dmfa_pkg::WORD_W-1:0] fill);
    mdl_valid[slot] = 1'b1;
    mdl_tag[slot]   = tag;
    mdl_count[slot] = dmfa_pkg::HITS_W'(1);
    mdl_data[slot]  = fill;
  endfunction

  function automatic void bump_count(input int unsigned slot);
    if (mdl_count[slot] != {dmfa_pkg::HITS_W{1'b1}})
      mdl_count[slot] = mdl_count[slot] + 1'b1;
  endfunction

  function automatic lookup_res_t predict_lookup(input logic [ADDR_W-1:0] addr,
                                                 input logic [dmfa_pkg::WORD_W-1:0] fill);
    lookup_res_t                 r;
    logic [BLK_W-1:0]            blk;
    logic [BLK_W-1:0]            tag;
    int unsigned                 slot;
    int unsigned                 victim;
    int unsigned                 i;
    logic [dmfa_pkg::HITS_W-1:0] best;
    bit                          have_best;
    bit                          done;
    r = '0;
    blk = addr[ADDR_W-1:OFF_W];
    slot = 0;
    victim = 0;
    best = '0;
    have_best = 1'b0;
    done = 1'b0;
    if (mdl_mode == dmfa_pkg::MODE_DIRECT) begin
      slot = blk % NLINES;
      tag = BLK_W'(blk / NLINES);
      if (mdl_valid[slot] && mdl_tag[slot] == tag) begin
        r.hit = 1'b1;
        bump_count(slot);
      end else begin
        r.repl = mdl_valid[slot];
        load_line(slot, tag, fill);
      end
    end else begin
      tag = blk;
      for (i = 0; i < NLINES && !done; i++) begin
        if (mdl_valid[i] && mdl_tag[i] == tag) begin
          r.hit = 1'b1;
          bump_count(i);
          slot = i;
          done = 1'b1;
        end else if (!mdl_valid[i]) begin
          load_line(i, tag, fill);
          slot = i;
          done = 1'b1;
        end else if (!have_best || mdl_count[i] < best) begin
          best = mdl_count[i];
          victim = i;
          have_best = 1'b1;
        end
      end
      if (!done) begin
        r.repl = 1'b1;
        load_line(victim, tag, fill);
        slot = victim;
      end
    end
    r.rd = dmfa_pkg::BYTE_W'(mdl_data[slot] >> (8 * addr[1:0]));
    r.line_idx = dmfa_pkg::USED_W'(slot);
    return r;
  endfunction

  // one request; the expectation is the typed one where given, else predicted
  task automatic issue_lookup(input logic [ADDR_W-1:0] addr,
                              input logic [dmfa_pkg::WORD_W-1:0] fill,
                              input logic typed, input lookup_res_t want);
    lookup_res_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({fill, addr});
    tx_live = 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = predict_lookup(addr, fill);
    pred_hits += pred.hit;
    pred_repls += pred.repl;
    pending_lookups.push_back(typed ? want : pred);
    sent_count++;
    if (gaps_enabled) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_tvalid <= 1'b0;
        tx_live = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 10);
      end
    end
  endtask

  task automatic drain_lookups();
    if (tx_live) begin
      s_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain_lookups();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_mode = mode;
    mode_writes++;
  endtask

  // receiver: free running or on a reloaded stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_free) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= rx_pat[rx_pos];
      rx_pos <= rx_pos + 1'b1;
      if (rx_pos == 4'hF)
        rx_pat <= 16'($urandom | $urandom);
    end
  end

  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected result", 0, 32'(m_tdata));
      end else begin
        want = pending_lookups.pop_front();
        if (m_tdata[7:0] !== want.rd)
          report_mismatch("read_data", 32'(want.rd), 32'(m_tdata[7:0]));
        if (m_tdata[8] !== want.hit)
          report_mismatch("hit", 32'(want.hit), 32'(m_tdata[8]));
        if (m_tdata[9] !== want.repl)
          report_mismatch("replaced", 32'(want.repl), 32'(m_tdata[9]));
        if (m_tdata[12:10] !== want.line_idx)
          report_mismatch("line_used", 32'(want.line_idx), 32'(m_tdata[12:10]));
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] work_set [12];
    logic [ADDR_W-1:0] addr;
    int                ph;
    int                n;
    int                k;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    mdl_mode = dmfa_pkg::MODE_DIRECT;
    for (k = 0; k < NLINES; k++) begin
      mdl_valid[k] = 1'b0;
      mdl_tag[k] = '0;
      mdl_count[k] = '0;
      mdl_data[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < NUM_DIRECTED; n++) begin
      if (directed_rows[n].kind == ROW_MODE)
        write_mode(directed_rows[n].mode);
      else
        issue_lookup(directed_rows[n].addr, directed_rows[n].fill,
                     directed_rows[n].typed, directed_rows[n].want);
    end

    // build uneven hit counts on one line, then force LFU replacements
    write_mode(dmfa_pkg::MODE_ASSOC);
    gaps_enabled = 1'b0;
    rx_free = 1'b1;
    for (n = 0; n < PREP_HITS; n++)
      issue_lookup(8'hC4, $urandom, 1'b0, '0);
    for (n = 0; n < 10; n++)
      issue_lookup(ADDR_W'(8'h84 + 4 * n), $urandom, 1'b0, '0);

    // random phases, alternating modes, mostly a small working set
    for (ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ? dmfa_pkg::MODE_DIRECT : dmfa_pkg::MODE_ASSOC);
      rx_free = (ph == 2);
      gaps_enabled = (ph != 3);
      for (k = 0; k < 12; k++)
        work_set[k] = ADDR_W'($urandom_range(0, 255));
      for (n = 0; n < 190; n++) begin
        if ($urandom_range(0, 9) < 7)
          addr = {work_set[$urandom_range(0, 11)][ADDR_W-1:OFF_W], OFF_W'($urandom)};
        else
          addr = ADDR_W'($urandom_range(0, 255));
        issue_lookup(addr, $urandom, 1'b0, '0);
      end
    end

    drain_lookups();
    repeat (40) @(posedge clk);
    $display("%0d requests (%0d hits, %0d replacements), %0d mode writes", sent_count,
             pred_hits, pred_repls, mode_writes);
    $display("both mappings, tags carried across mode changes and LFU victims exercised");
    if (err_count == 0) begin
      $display("dm_fa_lfu_cache_lookup_tb passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("dm_fa_lfu_cache_lookup_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_lookups.size());
    $display("dm_fa_lfu_cache_lookup_tb failed");
    $finish;
  end

endmodule

[sim.f]
src/dmfa_pkg.sv
src/dmfa_div.sv
src/dmfa_cell.sv
src/dm_fa_lfu_cache_lookup.sv
tb/dm_fa_lfu_cache_lookup_tb.sv
